/* src/wims_pkg.sv */
// ----------------------------------------------------------------------------
// wims_pkg
// Shared types and constants for the windowed infection model step unit.
// ----------------------------------------------------------------------------
package wims_pkg;

    // Default sizes
    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_VALUE_WIDTH = 48;

    // Port field widths
    localparam int FIELD_W   = 48;
    localparam int RATE_W    = 32;
    localparam int WLEN_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_COUNT = 6;

    // Shared multiplier: 64x64 product built from 32x32 partial products
    localparam int MUL_W   = 64;
    localparam int PART_W  = 32;
    localparam int PROD_W  = 128;
    localparam int MUL_CNT_W = 3;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = 3'd4;

    // Rate product keeps bits [95:32]; the second product drops 16 fraction bits
    localparam int P_LSB    = 32;
    localparam int FRAC_W   = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE = 3'd0,
        CFG_WLEN = 3'd1,
        CFG_NPOP = 3'd2,
        CFG_S0   = 3'd3,
        CFG_I0   = 3'd4,
        CFG_R0   = 3'd5
    } cfg_idx_t;

    // Step sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM1,
        ST_SUM2,
        ST_M1GO,
        ST_M1WAIT,
        ST_M2GO,
        ST_M2WAIT,
        ST_DELTA,
        ST_CALC,
        ST_FIN
    } state_t;

    // History memory command
    typedef struct packed {
        logic rd;
        logic wr;
    } ring_cmd_t;

endpackage

/* src/wims_ring.sv */
// ----------------------------------------------------------------------------
// wims_ring
// History memories for infected values and window sums, one shared address
// pair, registered read.
// ----------------------------------------------------------------------------
module wims_ring #(
    parameter int DEPTH = wims_pkg::DEF_MAX_WINDOW,
    parameter int INF_W = wims_pkg::DEF_VALUE_WIDTH,
    parameter int WS_W  = wims_pkg::DEF_VALUE_WIDTH + 7,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  wims_pkg::ring_cmd_t cmd,
    input  logic [AW-1:0]       rd_addr,
    input  logic [AW-1:0]       wr_addr,
    input  logic [INF_W-1:0]    wr_inf,
    input  logic [WS_W-1:0]     wr_ws,
    output logic [INF_W-1:0]    rd_inf,
    output logic [WS_W-1:0]     rd_ws
);

    logic [INF_W-1:0] inf_mem [DEPTH];
    logic [WS_W-1:0]  ws_mem  [DEPTH];
    logic [INF_W-1:0] rd_inf_reg;
    logic [WS_W-1:0]  rd_ws_reg;

    // Write the newest entries
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            inf_mem[wr_addr] <= wr_inf;
            ws_mem[wr_addr]  <= wr_ws;
        end
    end

    // Read the entries leaving the window
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_inf_reg <= inf_mem[rd_addr];
            rd_ws_reg  <= ws_mem[rd_addr];
        end
    end

    assign rd_inf = rd_inf_reg;
    assign rd_ws  = rd_ws_reg;

endmodule

/* src/wims_mul.sv */
// ----------------------------------------------------------------------------
// wims_mul
// Multicycle 64x64 unsigned multiplier: one registered 32x32 partial product
// per cycle, accumulated in the following cycle. Done pulses when the product is final.
// ----------------------------------------------------------------------------
module wims_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wims_pkg::MUL_W-1:0]  a,
    input  logic [wims_pkg::MUL_W-1:0]  b,
    output logic                        done,
    output logic [wims_pkg::PROD_W-1:0] prod
);

    logic                              busy_reg;
    logic [wims_pkg::MUL_CNT_W-1:0]    cnt_reg;
    logic                              done_reg;
    logic                              pp_vld_reg;
    logic [1:0]                        pp_sel_reg;
    logic [wims_pkg::MUL_W-1:0]        a_reg;
    logic [wims_pkg::MUL_W-1:0]        b_reg;
    logic [2*wims_pkg::PART_W-1:0]     pp_reg;
    logic [wims_pkg::PROD_W-1:0]       acc_reg;

    logic [wims_pkg::PART_W-1:0]       a_half;
    logic [wims_pkg::PART_W-1:0]       b_half;
    logic [2*wims_pkg::PART_W-1:0]     pp_next;
    logic [wims_pkg::PROD_W-1:0]       pp_shifted;

    // Pick halves: a half from bit 1 of the step, b half from bit 0
    always_comb
    begin
        a_half  = cnt_reg[1] ? a_reg[wims_pkg::MUL_W-1:wims_pkg::PART_W]
                             : a_reg[wims_pkg::PART_W-1:0];
        b_half  = cnt_reg[0] ? b_reg[wims_pkg::MUL_W-1:wims_pkg::PART_W]
                             : b_reg[wims_pkg::PART_W-1:0];
        pp_next = (2*wims_pkg::PART_W)'(a_half) * (2*wims_pkg::PART_W)'(b_half);
    end

    // Align the partial product to its column
    always_comb
    begin
        unique case (pp_sel_reg)
            2'd0:    pp_shifted = wims_pkg::PROD_W'(pp_reg);
            2'd3:    pp_shifted = wims_pkg::PROD_W'(pp_reg) << (2*wims_pkg::PART_W);
            default: pp_shifted = wims_pkg::PROD_W'(pp_reg) << wims_pkg::PART_W;
        endcase
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            pp_vld_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg   <= 1'b1;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            pp_vld_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            pp_vld_reg <= (cnt_reg != wims_pkg::MUL_LAST);
            done_reg   <= (cnt_reg == wims_pkg::MUL_LAST);
            busy_reg   <= (cnt_reg != wims_pkg::MUL_LAST);
            cnt_reg    <= cnt_reg + 1'b1;
        end
        else
        begin
            done_reg   <= 1'b0;
        end
    end

    // Operands, partial product and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            pp_reg     <= pp_next;
            pp_sel_reg <= cnt_reg[1:0];
            if (pp_vld_reg)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* src/windowed_infection_model_step_unit.sv */
// ----------------------------------------------------------------------------
// windowed_infection_model_step_unit
// One susceptible/infected time step per input item, with windowed sums kept
// in history memories and a shared multicycle multiplier.
// ----------------------------------------------------------------------------
// Each accepted item produces one result item, and the next item is taken
// once the current one has been written to the output register, so the
// unit does not take a new item before it is through with the last one. Most
// of each step is spent waiting on the shared 64x64 multiplier, which forms
// the rate product and the susceptible product as four partial products each,
// in sequence. Both window sums are kept as running totals: each step adds the
// newest value and subtracts the value leaving the window, read from the history
// memories. A configuration write to one of the six registers reloads the state
// from the registers in the following cycle; no input item is taken during that cycle.
// ----------------------------------------------------------------------------
module windowed_infection_model_step_unit #(
    parameter int MAX_WINDOW  = wims_pkg::DEF_MAX_WINDOW,
    parameter int VALUE_WIDTH = wims_pkg::DEF_VALUE_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [wims_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wims_pkg::FIELD_W-1:0]      cfg_data,
    // Input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wims_pkg::FIELD_W-1:0]      s_tdata,   // [47:0] removed_count
    input  logic [0:0]                        s_tuser,   // [0] removed_update
    // Result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [2*wims_pkg::FIELD_W-1:0]    m_tdata    // [47:0] susceptible_out,
                                                         // [95:48] infected_out
);

    localparam int VW    = VALUE_WIDTH;
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int IW    = VW + CW;
    localparam int WSW   = (IW > 64) ? 64 : IW;
    localparam int DW    = WSW + CW;
    localparam int OVF_L = wims_pkg::FRAC_W + VW;

    // Configuration registers
    logic [wims_pkg::RATE_W-1:0]  rate_reg;
    logic [wims_pkg::WLEN_W-1:0]  wlen_reg;
    logic [wims_pkg::FIELD_W-1:0] npop_reg;
    logic [wims_pkg::FIELD_W-1:0] s0_reg;
    logic [wims_pkg::FIELD_W-1:0] i0_reg;
    logic [wims_pkg::FIELD_W-1:0] r0_reg;
    logic                         init_pend_reg;

    // Model state
    logic [VW-1:0]  sus_reg;
    logic [VW-1:0]  inf_reg;
    logic [VW-1:0]  rem_reg;
    logic [IW-1:0]  itot_reg;
    logic [DW-1:0]  dtot_reg;
    logic [CW-1:0]  steps_reg;
    logic [AW-1:0]  head_reg;

    // Step working registers
    wims_pkg::state_t state_reg;
    wims_pkg::state_t state_next;
    logic [WSW-1:0] ws_reg;
    logic [VW-1:0]  delta_reg;
    logic [VW:0]    t_reg;
    logic [VW-1:0]  snew_reg;

    // Output register
    logic                         out_valid_reg;
    logic [wims_pkg::FIELD_W-1:0] out_s_reg;
    logic [wims_pkg::FIELD_W-1:0] out_i_reg;

    // Internal nets
    wims_pkg::ring_cmd_t ring_cmd;
    logic [AW-1:0]  rd_addr;
    logic [VW-1:0]  rd_inf;
    logic [WSW-1:0] rd_ws;
    logic [CW-1:0]  w_eff;
    logic           full;
    logic [CW:0]    head_x;
    logic [CW:0]    w_x;
    logic [CW:0]    rd_x;
    logic [IW-1:0]  itot_next;
    logic [WSW-1:0] ws_next;
    logic [DW-1:0]  dtot_next;
    logic [wims_pkg::MUL_W-1:0]  sum64;
    logic                        mul_start;
    logic [wims_pkg::MUL_W-1:0]  mul_a;
    logic [wims_pkg::MUL_W-1:0]  mul_b;
    logic                        mul_done;
    logic [wims_pkg::PROD_W-1:0] mul_prod;
    logic [VW-1:0]  delta_next;
    logic [VW:0]    idiff;
    logic [VW-1:0]  inf_next;
    logic [VW-1:0]  n_val;
    logic [VW:0]    used;
    logic [VW-1:0]  s_init;
    logic           accept;
    logic           slot_free;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == wims_pkg::ST_IDLE) && !init_pend_reg;
    assign slot_free = !out_valid_reg || m_tready;

    // Effective window: zero acts as one, clamp at the history depth
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(wlen_reg) > 32'(MAX_WINDOW))
        begin
            w_eff = CW'(MAX_WINDOW);
        end
        else
        begin
            w_eff = CW'(wlen_reg);
        end
    end

    // Window is full once w steps are in history; oldest entry sits w behind head
    always_comb
    begin
        full    = (steps_reg >= w_eff);
        head_x  = (CW+1)'(head_reg);
        w_x     = (CW+1)'(w_eff);
        rd_x    = (head_x >= w_x) ? (head_x - w_x)
                                  : (head_x + (CW+1)'(MAX_WINDOW) - w_x);
        rd_addr = rd_x[AW-1:0];
    end

    // Running window totals
    always_comb
    begin
        itot_next = itot_reg + IW'(inf_reg) - (full ? IW'(rd_inf) : IW'(0));
        ws_next   = (itot_next > IW'({WSW{1'b1}})) ? {WSW{1'b1}} : WSW'(itot_next);
        dtot_next = dtot_reg + DW'(ws_reg) - (full ? DW'(rd_ws) : DW'(0));
        sum64     = (dtot_reg > DW'({wims_pkg::MUL_W{1'b1}})) ? {wims_pkg::MUL_W{1'b1}}
                                                              : wims_pkg::MUL_W'(dtot_reg);
    end

    // Multiplier operands: rate product first, then the susceptible product
    always_comb
    begin
        mul_start = (state_reg == wims_pkg::ST_M1GO) || (state_reg == wims_pkg::ST_M2GO);
        if (state_reg == wims_pkg::ST_M2GO)
        begin
            mul_a = mul_prod[wims_pkg::P_LSB +: wims_pkg::MUL_W];
            mul_b = wims_pkg::MUL_W'(sus_reg);
        end
        else
        begin
            mul_a = sum64;
            mul_b = wims_pkg::MUL_W'(rate_reg);
        end
    end

    // Delta saturates at the value maximum; infected clamps at zero and maximum
    always_comb
    begin
        delta_next = (|mul_prod[wims_pkg::PROD_W-1:OVF_L]) ? {VW{1'b1}}
                                                           : mul_prod[wims_pkg::FRAC_W +: VW];
        idiff      = (t_reg > (VW+1)'(rem_reg)) ? (t_reg - (VW+1)'(rem_reg)) : '0;
        inf_next   = idiff[VW] ? {VW{1'b1}} : idiff[VW-1:0];
    end

    // Starting susceptible: given value, or N - I - R floored at zero
    always_comb
    begin
        n_val = VW'(npop_reg);
        used  = (VW+1)'(VW'(i0_reg)) + (VW+1)'(VW'(r0_reg));
        if (s0_reg != '0)
        begin
            s_init = VW'(s0_reg);
        end
        else if ((VW+1)'(n_val) > used)
        begin
            s_init = VW'((VW+1)'(n_val) - used);
        end
        else
        begin
            s_init = '0;
        end
    end

    // Memory command: read the leaving entries on accept, write the new ones in SUM2
    always_comb
    begin
        ring_cmd.rd = accept;
        ring_cmd.wr = (state_reg == wims_pkg::ST_SUM2);
    end

    // Capture configuration writes and flag a reload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= '0;
            wlen_reg      <= wims_pkg::WLEN_W'(1);
            npop_reg      <= '0;
            s0_reg        <= '0;
            i0_reg        <= '0;
            r0_reg        <= '0;
            init_pend_reg <= 1'b0;
        end
        else
        begin
            init_pend_reg <= cfg_we && (cfg_index < wims_pkg::CFG_IDX_W'(wims_pkg::CFG_COUNT));
            if (cfg_we)
            begin
                unique case (wims_pkg::cfg_idx_t'(cfg_index))
                    wims_pkg::CFG_RATE: rate_reg <= cfg_data[wims_pkg::RATE_W-1:0];
                    wims_pkg::CFG_WLEN: wlen_reg <= cfg_data[wims_pkg::WLEN_W-1:0];
                    wims_pkg::CFG_NPOP: npop_reg <= cfg_data;
                    wims_pkg::CFG_S0:   s0_reg   <= cfg_data;
                    wims_pkg::CFG_I0:   i0_reg   <= cfg_data;
                    wims_pkg::CFG_R0:   r0_reg   <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wims_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wims_pkg::ST_IDLE:   if (accept) state_next = wims_pkg::ST_SUM1;
            wims_pkg::ST_SUM1:   state_next = wims_pkg::ST_SUM2;
            wims_pkg::ST_SUM2:   state_next = wims_pkg::ST_M1GO;
            wims_pkg::ST_M1GO:   state_next = wims_pkg::ST_M1WAIT;
            wims_pkg::ST_M1WAIT: if (mul_done) state_next = wims_pkg::ST_M2GO;
            wims_pkg::ST_M2GO:   state_next = wims_pkg::ST_M2WAIT;
            wims_pkg::ST_M2WAIT: if (mul_done) state_next = wims_pkg::ST_DELTA;
            wims_pkg::ST_DELTA:  state_next = wims_pkg::ST_CALC;
            wims_pkg::ST_CALC:   state_next = wims_pkg::ST_FIN;
            wims_pkg::ST_FIN:    if (slot_free) state_next = wims_pkg::ST_IDLE;
            default:             state_next = wims_pkg::ST_IDLE;
        endcase
    end

    // Model state: reload on configuration, else update field by field in each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sus_reg   <= '0;
            inf_reg   <= '0;
            rem_reg   <= '0;
            itot_reg  <= '0;
            dtot_reg  <= '0;
            steps_reg <= '0;
            head_reg  <= '0;
        end
        else if (init_pend_reg)
        begin
            sus_reg   <= s_init;
            inf_reg   <= VW'(i0_reg);
            rem_reg   <= VW'(r0_reg);
            itot_reg  <= '0;
            dtot_reg  <= '0;
            steps_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            if (accept && s_tuser[0])
            begin
                rem_reg <= VW'(s_tdata);
            end
            if (state_reg == wims_pkg::ST_SUM1)
            begin
                itot_reg <= itot_next;
            end
            if (state_reg == wims_pkg::ST_SUM2)
            begin
                dtot_reg <= dtot_next;
            end
            if ((state_reg == wims_pkg::ST_FIN) && slot_free)
            begin
                sus_reg  <= snew_reg;
                inf_reg  <= inf_next;
                head_reg <= (head_reg == AW'(MAX_WINDOW - 1)) ? '0 : head_reg + 1'b1;
                if (steps_reg < CW'(MAX_WINDOW))
                begin
                    steps_reg <= steps_reg + 1'b1;
                end
            end
        end
    end

    // Step working values
    always_ff @(posedge clk)
    begin
        if (state_reg == wims_pkg::ST_SUM1)
        begin
            ws_reg <= ws_next;
        end
        if (state_reg == wims_pkg::ST_DELTA)
        begin
            delta_reg <= delta_next;
        end
        if (state_reg == wims_pkg::ST_CALC)
        begin
            t_reg    <= (VW+1)'(inf_reg) + (VW+1)'(delta_reg);
            snew_reg <= (sus_reg > delta_reg) ? (sus_reg - delta_reg) : '0;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == wims_pkg::ST_FIN) && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == wims_pkg::ST_FIN) && slot_free)
        begin
            out_s_reg <= wims_pkg::FIELD_W'(snew_reg);
            out_i_reg <= wims_pkg::FIELD_W'(inf_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_i_reg, out_s_reg};

    // History memories
    wims_ring #(
        .DEPTH (MAX_WINDOW),
        .INF_W (VW),
        .WS_W  (WSW),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .cmd     (ring_cmd),
        .rd_addr (rd_addr),
        .wr_addr (head_reg),
        .wr_inf  (inf_reg),
        .wr_ws   (ws_reg),
        .rd_inf  (rd_inf),
        .rd_ws   (rd_ws)
    );

    // Shared multiplier
    wims_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Multiplier finishes only while the sequencer waits for it
    a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == wims_pkg::ST_M1WAIT || state_reg == wims_pkg::ST_M2WAIT))
        else $error("multiplier done outside a wait state");

    // Step count never passes the history depth
    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= CW'(MAX_WINDOW))
        else $error("step count beyond history depth");

    // A new result appears only from the final step state
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == wims_pkg::ST_FIN))
        else $error("result raised outside final state");

    // An accepted item starts the summing phase
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == wims_pkg::ST_SUM1))
        else $error("accepted item did not start a step");

    // History read and write never share a cycle
    a_ring_excl: assert property (@(posedge clk) disable iff (!rst_n)
        ring_cmd.wr |-> !ring_cmd.rd)
        else $error("history read and write in the same cycle");

endmodule
